### sv/lcd_window_command_sequencer_assert.svh
// assertion macros shared by the sequencer; clock and reset are the block's own port names
`ifndef LCD_WINDOW_COMMAND_SEQUENCER_ASSERT_SVH
`define LCD_WINDOW_COMMAND_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define LCDWCS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LCDWCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lcdwcs_pkg.sv
package lcdwcs_pkg;

   localparam int FUNC_W = 3;
   localparam int DATA_W = 32;

   // request kinds, same codes as the func field
   localparam logic [FUNC_W-1:0] FUNC_AREA   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PIXEL  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SCROLL = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_ORIENT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_INVERT = 3'd4;

   localparam logic [1:0] ORIENT_UP    = 2'd0;
   localparam logic [1:0] ORIENT_DOWN  = 2'd1;
   localparam logic [1:0] ORIENT_LEFT  = 2'd2;
   localparam logic [1:0] ORIENT_RIGHT = 2'd3;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIENTATION   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BGR_FILTER    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL_HEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_WIDTH     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_HEIGHT    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_OFFSET = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_OFFSET    = 3'd7;

   localparam logic [7:0] CMD_COLUMN_SET     = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET        = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE   = 8'h2C;
   localparam logic [7:0] CMD_SCROLL_START   = 8'h37;
   localparam logic [7:0] CMD_ACCESS_CONTROL = 8'h36;
   localparam logic [7:0] CMD_INVERT_ON      = 8'h21;
   localparam logic [7:0] CMD_INVERT_OFF     = 8'h20;
   localparam logic [7:0] MADCTL_UP    = 8'hC0;
   localparam logic [7:0] MADCTL_LEFT  = 8'hA0;
   localparam logic [7:0] MADCTL_RIGHT = 8'h60;
   localparam logic [7:0] MADCTL_BGR   = 8'h08;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_AREA_LAST = 4'd10;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int SCROLL_ROWS_W = 9;
   localparam int SCROLL_SUM_W = 10;
   localparam int SCROLL_MAG_W = 9;
   localparam int SCROLL_CNT_W = $clog2(SCROLL_MAG_W + 1);

   typedef struct packed {
      logic [FUNC_W-1:0] kind;
      logic [DATA_W-1:0] data;
   } item_type;

   typedef struct packed {
      logic [1:0] orientation;
      logic       bgr_filter;
      logic [7:0] panel_width;
      logic [7:0] panel_height;
      logic [7:0] ram_width;
      logic [7:0] ram_height;
      logic [7:0] column_offset;
      logic [7:0] row_offset;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      orientation:   ORIENT_UP,
      bgr_filter:    1'b1,
      panel_width:   8'd128,
      panel_height:  8'd128,
      ram_width:     8'd132,
      ram_height:    8'd132,
      column_offset: 8'd2,
      row_offset:    8'd1
   };

   typedef struct packed {
      logic              busy;
      logic [FUNC_W-1:0] kind;
      logic [STEP_W-1:0] step;
   } back_status_type;

endpackage

### sv/lcdwcs_front.sv
module lcdwcs_front
   import lcdwcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_func,
   input  logic [7:0]        req_x_first,
   input  logic [7:0]        req_y_first,
   input  logic [7:0]        req_x_last,
   input  logic [7:0]        req_y_last,
   input  logic [15:0]       req_pixel_color,
   input  logic signed [8:0] req_scroll_rows,
   input  logic              req_invert_on,
   output logic              item_valid,
   output item_type          item,
   input  logic              item_ready
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic              known;
   logic [DATA_W-1:0] packed_data;
   logic              take;

   // pack only the fields the request kind uses, drop unused codes
   always_comb begin
      known = 1'b1;
      packed_data = '0;
      case (req_func)
         FUNC_AREA: begin
            packed_data = {req_x_first, req_y_first, req_x_last, req_y_last};
         end
         FUNC_PIXEL: begin
            packed_data = {16'd0, req_pixel_color};
         end
         FUNC_SCROLL: begin
            packed_data = {23'd0, req_scroll_rows};
         end
         FUNC_ORIENT: begin
            packed_data = '0;
         end
         FUNC_INVERT: begin
            packed_data = {31'd0, req_invert_on};
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign req_stall = valid_ff & ~item_ready;
   assign take = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff & ~item_ready;
      item_in = item_ff;
      if (take) begin
         valid_in = known;
         item_in.kind = req_func;
         item_in.data = packed_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

### sv/lcdwcs_queue.sv
module lcdwcs_queue
   import lcdwcs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop_en
);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              full, push, pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop = pop_en & pop_valid;
   // a slot freed this cycle can be refilled at once
   assign push_ready = ~full | pop;
   assign push = push_valid & push_ready;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### sv/lcdwcs_scroll.sv
module lcdwcs_scroll
   import lcdwcs_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [SCROLL_ROWS_W-1:0] rows,
   input  logic [7:0]                     height,
   output logic                           busy,
   output logic [7:0]                     first_row
);

   logic                    busy_ff, busy_in;
   logic [7:0]              row_ff, row_in;
   logic [SCROLL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SCROLL_MAG_W-1:0] mag_ff, mag_in;
   logic [7:0]              rem_ff, rem_in;
   logic [7:0]              h_ff, h_in;
   logic                    neg_ff, neg_in;
   logic [SCROLL_SUM_W-1:0] sum;
   logic [SCROLL_SUM_W-1:0] sum_abs;
   logic [8:0]              trial;

   // signed sum of position and rows, then its magnitude
   assign sum = {2'b00, row_ff} + {rows[SCROLL_ROWS_W-1], rows};
   assign sum_abs = sum[SCROLL_SUM_W-1] ? (~sum + 1'b1) : sum;
   assign trial = {rem_ff, mag_ff[SCROLL_MAG_W-1]};

   always_comb begin
      busy_in = busy_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      mag_in = mag_ff;
      rem_in = rem_ff;
      h_in = h_ff;
      neg_in = neg_ff;
      if (start) begin
         if (height == 8'd0) begin
            row_in = '0;
         end else begin
            busy_in = 1'b1;
            cnt_in = '0;
            mag_in = sum_abs[SCROLL_MAG_W-1:0];
            rem_in = '0;
            neg_in = sum[SCROLL_SUM_W-1];
            h_in = height;
         end
      end else if (busy_ff) begin
         if (cnt_ff == SCROLL_CNT_W'(SCROLL_MAG_W)) begin
            // negative sums wrap up from the height
            row_in = (neg_ff && rem_ff != 8'd0) ? h_ff - rem_ff : rem_ff;
            busy_in = 1'b0;
         end else begin
            rem_in = (trial >= {1'b0, h_ff}) ? 8'(trial - {1'b0, h_ff}) : trial[7:0];
            mag_in = {mag_ff[SCROLL_MAG_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff <= '0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      h_ff <= h_in;
      neg_ff <= neg_in;
   end

   assign busy = busy_ff;
   assign first_row = row_ff;

endmodule

### sv/lcdwcs_back.sv
module lcdwcs_back
   import lcdwcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     q_valid,
   input  item_type                 q_item,
   output logic                     q_pop,
   output logic                     scr_start,
   output logic [SCROLL_ROWS_W-1:0] scr_rows,
   input  logic                     scr_busy,
   input  logic [7:0]               scr_first_row,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_is_command,
   output logic                     rsp_last,
   output back_status_type          status
);

   logic              busy_ff, busy_in;
   logic [FUNC_W-1:0] kind_ff, kind_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [15:0] up_add_ff;
   logic [7:0]  col_add_ff, col_add_in;
   logic [7:0]  row_add_ff, row_add_in;
   logic [7:0]  far_x, far_y;

   logic [15:0] xs_rot_ff, ys_rot_ff, xe_rot_ff, ye_rot_ff;
   logic [15:0] xs_rot_in, ys_rot_in, xe_rot_in, ye_rot_in;
   logic [7:0]  xs_ff, ys_ff, xe_ff, ye_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_cmd_ff, rsp_last_ff;

   logic [7:0] cur_byte;
   logic       cur_cmd, cur_last, cur_ready;
   logic [7:0] madctl;
   logic       emit_ok, fire;

   function automatic logic [7:0] wrap_panel(input logic [15:0] v, input logic [7:0] h);
      logic [15:0] hv;
      hv = {8'd0, h};
      return (v >= hv) ? 8'(v - hv) : v[7:0];
   endfunction

   // frame offsets, rebuilt each cycle from the stable config
   assign far_x = cfg.ram_width - cfg.panel_width - cfg.column_offset;
   assign far_y = cfg.ram_height - cfg.panel_height - cfg.row_offset;

   always_comb begin
      case (cfg.orientation)
         ORIENT_UP: begin
            col_add_in = far_x;
            row_add_in = far_y;
         end
         ORIENT_DOWN: begin
            col_add_in = cfg.column_offset;
            row_add_in = cfg.row_offset;
         end
         ORIENT_LEFT: begin
            col_add_in = far_y;
            row_add_in = cfg.column_offset;
         end
         default: begin
            col_add_in = cfg.row_offset;
            row_add_in = far_x;
         end
      endcase
   end

   // rotation of both corners, registered, then reduced by the panel height
   always_comb begin
      xs_rot_in = {8'd0, data_ff[31:24]};
      ys_rot_in = {8'd0, data_ff[23:16]};
      xe_rot_in = {8'd0, data_ff[15:8]};
      ye_rot_in = {8'd0, data_ff[7:0]};
      case (cfg.orientation)
         ORIENT_UP: begin
            ys_rot_in = ys_rot_in + up_add_ff;
            ye_rot_in = ye_rot_in + up_add_ff;
         end
         ORIENT_DOWN: begin
            ys_rot_in = ys_rot_in + {8'd0, scr_first_row};
            ye_rot_in = ye_rot_in + {8'd0, scr_first_row};
         end
         ORIENT_LEFT: begin
            xs_rot_in = xs_rot_in + up_add_ff;
            xe_rot_in = xe_rot_in + up_add_ff;
         end
         default: begin
            xs_rot_in = xs_rot_in + {8'd0, scr_first_row};
            xe_rot_in = xe_rot_in + {8'd0, scr_first_row};
         end
      endcase
   end

   always_comb begin
      madctl = cfg.bgr_filter ? MADCTL_BGR : 8'd0;
      case (cfg.orientation)
         ORIENT_UP:    madctl = madctl | MADCTL_UP;
         ORIENT_DOWN:  madctl = madctl;
         ORIENT_LEFT:  madctl = madctl | MADCTL_LEFT;
         default:      madctl = madctl | MADCTL_RIGHT;
      endcase
   end

   // byte for the current step
   always_comb begin
      cur_byte = 8'd0;
      cur_cmd = 1'b0;
      cur_last = 1'b0;
      cur_ready = 1'b1;
      case (kind_ff)
         FUNC_AREA: begin
            case (step_ff)
               4'd0: begin
                  cur_byte = CMD_COLUMN_SET;
                  cur_cmd = 1'b1;
               end
               4'd2: cur_byte = xs_ff + col_add_ff;
               4'd4: cur_byte = xe_ff + col_add_ff;
               4'd5: begin
                  cur_byte = CMD_ROW_SET;
                  cur_cmd = 1'b1;
               end
               4'd7: cur_byte = ys_ff + row_add_ff;
               4'd9: cur_byte = ye_ff + row_add_ff;
               STEP_AREA_LAST: begin
                  cur_byte = CMD_MEMORY_WRITE;
                  cur_cmd = 1'b1;
                  cur_last = 1'b1;
               end
               default: cur_byte = 8'd0;
            endcase
         end
         FUNC_PIXEL: begin
            if (step_ff == '0) begin
               cur_byte = data_ff[15:8];
            end else begin
               cur_byte = data_ff[7:0];
               cur_last = 1'b1;
            end
         end
         FUNC_SCROLL: begin
            case (step_ff)
               4'd0: begin
                  cur_byte = CMD_SCROLL_START;
                  cur_cmd = 1'b1;
               end
               4'd1: cur_byte = 8'd0;
               default: begin
                  // waits for the new first row
                  cur_byte = cfg.row_offset + scr_first_row;
                  cur_last = 1'b1;
                  cur_ready = ~scr_busy;
               end
            endcase
         end
         FUNC_ORIENT: begin
            if (step_ff == '0) begin
               cur_byte = CMD_ACCESS_CONTROL;
               cur_cmd = 1'b1;
            end else begin
               cur_byte = madctl;
               cur_last = 1'b1;
            end
         end
         default: begin
            cur_byte = data_ff[0] ? CMD_INVERT_ON : CMD_INVERT_OFF;
            cur_cmd = 1'b1;
            cur_last = 1'b1;
         end
      endcase
   end

   assign emit_ok = ~rsp_valid_ff | ~rsp_stall;
   assign fire = busy_ff & emit_ok & cur_ready;
   assign q_pop = q_valid & (~busy_ff | (fire & cur_last));
   assign scr_start = q_pop & (q_item.kind == FUNC_SCROLL);
   assign scr_rows = q_item.data[SCROLL_ROWS_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      data_in = data_ff;
      step_in = step_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         kind_in = q_item.kind;
         data_in = q_item.data;
         step_in = '0;
      end else if (fire) begin
         busy_in = ~cur_last;
         step_in = step_ff + 1'b1;
      end
   end

   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      data_ff <= data_in;
      up_add_ff <= {8'd0, cfg.panel_height} + {8'd0, cfg.row_offset}
                   - {8'd0, scr_first_row} - 16'd1;
      col_add_ff <= col_add_in;
      row_add_ff <= row_add_in;
      xs_rot_ff <= xs_rot_in;
      ys_rot_ff <= ys_rot_in;
      xe_rot_ff <= xe_rot_in;
      ye_rot_ff <= ye_rot_in;
      xs_ff <= wrap_panel(xs_rot_ff, cfg.panel_height);
      ys_ff <= wrap_panel(ys_rot_ff, cfg.panel_height);
      xe_ff <= wrap_panel(xe_rot_ff, cfg.panel_height);
      ye_ff <= wrap_panel(ye_rot_ff, cfg.panel_height);
      if (fire) begin
         rsp_byte_ff <= cur_byte;
         rsp_cmd_ff <= cur_cmd;
         rsp_last_ff <= cur_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_is_command = rsp_cmd_ff;
   assign rsp_last = rsp_last_ff;

   assign status.busy = busy_ff;
   assign status.kind = kind_ff;
   assign status.step = step_ff;

endmodule

### sv/lcd_window_command_sequencer.sv
// Byte sequencer for a small serial colour LCD controller.
// req_*: one drawing request per accepted item (req_valid high, req_stall low).
//   func 0 area window, 1 pixel, 2 scroll, 3 access control, 4 inversion;
//   codes 5 to 7 are accepted and produce nothing.
// rsp_*: one byte per accepted item, rsp_is_command high for a command byte,
//   rsp_last high on the final byte of a request.
// csr_*: register writes, always ready; write only while no request is in flight.
// Path: an accepted request passes through the front register, the queue, the back
//   sequencer and the output register before its first byte is valid.
// Throughput: the output register carries one byte per cycle while rsp_stall is low;
//   a pixel is 2 bytes, access control 2, inversion 1 and an area window 11. A
//   scroll is 3 bytes, and its last byte waits for the shift-subtract remainder
//   unit that wraps the first row by the panel height.
// A stalled output holds its byte; the two-entry queue and the front register
//   keep accepting until both are full.
// Reset (synchronous): queue empty, scroll position 0, registers at defaults.
`include "lcd_window_command_sequencer_assert.svh"

module lcd_window_command_sequencer
   import lcdwcs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_func,
   input  logic [7:0]             req_x_first,
   input  logic [7:0]             req_y_first,
   input  logic [7:0]             req_x_last,
   input  logic [7:0]             req_y_last,
   input  logic [15:0]            req_pixel_color,
   input  logic signed [8:0]      req_scroll_rows,
   input  logic                   req_invert_on,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_command,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic            fe_valid;
   item_type        fe_item;
   logic            q_ready;
   logic            q_valid;
   item_type        q_item;
   logic            q_pop;
   logic            scr_start;
   logic [SCROLL_ROWS_W-1:0] scr_rows;
   logic            scr_busy;
   logic [7:0]      scr_first_row;
   back_status_type bk_status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIENTATION:   cfg_in.orientation = csr_data[1:0];
            CSR_BGR_FILTER:    cfg_in.bgr_filter = csr_data[0];
            CSR_PANEL_WIDTH:   cfg_in.panel_width = csr_data;
            CSR_PANEL_HEIGHT:  cfg_in.panel_height = csr_data;
            CSR_RAM_WIDTH:     cfg_in.ram_width = csr_data;
            CSR_RAM_HEIGHT:    cfg_in.ram_height = csr_data;
            CSR_COLUMN_OFFSET: cfg_in.column_offset = csr_data;
            CSR_ROW_OFFSET:    cfg_in.row_offset = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcdwcs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_x_first     (req_x_first),
      .req_y_first     (req_y_first),
      .req_x_last      (req_x_last),
      .req_y_last      (req_y_last),
      .req_pixel_color (req_pixel_color),
      .req_scroll_rows (req_scroll_rows),
      .req_invert_on   (req_invert_on),
      .item_valid      (fe_valid),
      .item            (fe_item),
      .item_ready      (q_ready)
   );

   lcdwcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_item  (fe_item),
      .push_ready (q_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop_en     (q_pop)
   );

   lcdwcs_scroll u_scroll (
      .clock     (clock),
      .reset     (reset),
      .start     (scr_start),
      .rows      ($signed(scr_rows)),
      .height    (cfg_ff.panel_height),
      .busy      (scr_busy),
      .first_row (scr_first_row)
   );

   lcdwcs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .scr_start      (scr_start),
      .scr_rows       (scr_rows),
      .scr_busy       (scr_busy),
      .scr_first_row  (scr_first_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_command (rsp_is_command),
      .rsp_last       (rsp_last),
      .status         (bk_status)
   );

   `LCDWCS_ASSERT_IMPLIES(a_scroll_owned, scr_busy,
      (bk_status.busy && bk_status.kind == FUNC_SCROLL),
      "remainder unit busy without a scroll request in the back end")
   `LCDWCS_ASSERT_IMPLIES(a_step_range, bk_status.busy, (bk_status.step <= STEP_AREA_LAST),
      "sequencer step beyond the longest request")
   `LCDWCS_ASSERT_IMPLIES(a_mem_write_last,
      (rsp_valid && rsp_is_command && rsp_out_byte == CMD_MEMORY_WRITE), rsp_last,
      "memory write command not marked as last byte")
   `LCDWCS_ASSERT_NEXT(a_scroll_starts, (scr_start && cfg_ff.panel_height != 8'd0), scr_busy,
      "scroll start did not occupy the remainder unit")

endmodule
